// File: hw/rtl/crf_pkg.sv
// Shared types, constants and index helpers for the character ring FIFO.
// No dependencies; imported by crf_front, crf_back and the top level.
package crf_pkg;

	localparam int DEPTH         = 16;
	localparam int PATTERN_CHARS = 8;
	localparam int QUEUE_DEPTH   = 2;

	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int PLEN_W = $clog2(PATTERN_CHARS + 1);
	localparam int PAT_W  = 8 * PATTERN_CHARS;

	// field widths fixed by the interface
	localparam int CAP_W   = 5;
	localparam int LEN_W   = 4;
	localparam int FILL_W  = 5;
	localparam int REQ_W   = 5;
	localparam int CIDX_W  = 3;
	localparam int CDATA_W = 64;

	// command codes
	localparam logic [1:0] CMD_PUSH = 2'd0;
	localparam logic [1:0] CMD_POP  = 2'd1;
	localparam logic [1:0] CMD_PEEK = 2'd2;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_CAPACITY  = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_BEGIN_PAT = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_BEGIN_LEN = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_END_PAT   = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_END_LEN   = 3'd4;

	// register reset values
	localparam logic [CAP_W-1:0]   CAPACITY_RST  = 5'd16;
	localparam logic [CDATA_W-1:0] BEGIN_PAT_RST = 64'd3355185;
	localparam logic [LEN_W-1:0]   BEGIN_LEN_RST = 4'd3;
	localparam logic [CDATA_W-1:0] END_PAT_RST   = 64'd1684234849;
	localparam logic [LEN_W-1:0]   END_LEN_RST   = 4'd4;

	typedef enum logic [1:0] {
		OP_PUSH,
		OP_POP,
		OP_PEEK,
		OP_NOP
	} crf_op_t;

	typedef struct packed {
		logic [1:0]       command;
		logic [7:0]       char_in;
		logic [REQ_W-1:0] request_count;
	} crf_item_t;

	typedef struct packed {
		logic [7:0]        char_out;
		logic              char_valid;
		logic              last;
		logic [FILL_W-1:0] fill_count;
		logic              begins_match;
		logic              ends_match;
	} crf_result_t;

	// classified command handed from front to back
	typedef struct packed {
		crf_op_t          op;
		logic [7:0]       ch;
		logic [REQ_W-1:0] req;
	} crf_job_t;

	// ring index plus offset (offset may be DEPTH), wrapped into the ring
	function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] idx,
			input logic [CNT_W-1:0] off);
		logic [CNT_W:0] s;
		s = {{(CNT_W + 1 - IDX_W){1'b0}}, idx} + {1'b0, off};
		if (s >= (CNT_W + 1)'(DEPTH))
			s = s - (CNT_W + 1)'(DEPTH);
		return s[IDX_W-1:0];
	endfunction

	function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
		if (cap == '0)
			return CNT_W'(1);
		if (int'(cap) > DEPTH)
			return CNT_W'(DEPTH);
		return CNT_W'(cap);
	endfunction

	function automatic logic [PLEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
		if (int'(len) > PATTERN_CHARS)
			return PLEN_W'(PATTERN_CHARS);
		return PLEN_W'(len);
	endfunction

endpackage

// File: hw/rtl/crf_front.sv
// Command front end: takes start transfers, classifies the command and
// queues it for the back end. Depends on crf_pkg.
module crf_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  crf_pkg::crf_item_t item,
	output logic               job_valid,
	output crf_pkg::crf_job_t  job,
	input  logic               job_take
);
	import crf_pkg::*;

	localparam int QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

	crf_job_t          queue_q [QUEUE_DEPTH];
	logic [QP_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QC_W-1:0]   cnt_q;
	crf_job_t          new_job;
	logic              push;

	always_comb begin
		new_job.ch  = item.char_in;
		new_job.req = item.request_count;
		unique case (item.command)
			CMD_PUSH: new_job.op = OP_PUSH;
			CMD_POP:  new_job.op = OP_POP;
			CMD_PEEK: new_job.op = OP_PEEK;
			default:  new_job.op = OP_NOP;
		endcase
	end

	assign busy      = (cnt_q == QC_W'(QUEUE_DEPTH));
	assign push      = start && !busy;
	assign job_valid = (cnt_q != '0);
	assign job       = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			queue_q[wr_ptr_q] <= new_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (job_take)
				rd_ptr_q <= (rd_ptr_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !job_take)
				cnt_q <= cnt_q + 1'b1;
			else if (!push && job_take)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QC_W'(QUEUE_DEPTH))
		else $error("queue count above depth");

	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		job_take |-> job_valid)
		else $error("job taken from empty queue");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !job_take) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("accepted command not counted");

endmodule

// File: hw/rtl/crf_back.sv
// Execution back end: character ring store, configuration registers,
// pattern match walk and result sequencing. Depends on crf_pkg.
module crf_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      job_valid,
	input  crf_pkg::crf_job_t         job,
	output logic                      job_take,
	input  logic                      cfg_we,
	input  logic [crf_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [crf_pkg::CDATA_W-1:0] cfg_data,
	output logic                      result_valid,
	output crf_pkg::crf_result_t      result
);
	import crf_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_EMIT = 3'b100
	} st_t;

	st_t                state_q;

	// configuration
	logic [CAP_W-1:0]   capacity_q;
	logic [PAT_W-1:0]   bpat_q, epat_q;
	logic [LEN_W-1:0]   blen_q, elen_q;

	// ring state
	logic [7:0]         mem [DEPTH];
	logic [IDX_W-1:0]   oldest_q;
	logic [CNT_W-1:0]   fill_q;

	// walk and emission
	logic [IDX_W-1:0]   pa_q, sa_q, ea_q;
	logic [PLEN_W-1:0]  wc_q;
	logic               bm_q, em_q;
	logic [CNT_W-1:0]   left_q;
	logic               zero_q;
	logic [7:0]         rd_a_q, rd_b_q;
	logic               rv_s1;
	logic [PLEN_W-1:0]  ri_s1;

	logic               e_vld_s1, e_cv_s1, e_last_s1, e_bm_s1, e_em_s1;
	logic [CNT_W-1:0]   e_fill_s1;

	// next-state values for a job
	logic [CNT_W-1:0]   cap_eff, n_cnt, nf;
	logic [IDX_W-1:0]   no, wr_addr, rd_addr_a;
	logic               mem_we;
	logic [PLEN_W-1:0]  blen_eff, elen_eff;
	logic               blen_ok, elen_ok;
	logic [CNT_W-1:0]   trim_cap;

	assign cap_eff  = eff_cap(capacity_q);
	assign blen_eff = eff_len(blen_q);
	assign elen_eff = eff_len(elen_q);
	assign wr_addr  = wrap_add(oldest_q, fill_q);
	assign job_take = (state_q == ST_IDLE) && job_valid;
	assign mem_we   = job_take && (job.op == OP_PUSH);
	assign trim_cap = eff_cap(cfg_data[CAP_W-1:0]);

	always_comb begin
		n_cnt = '0;
		nf    = fill_q;
		no    = oldest_q;
		case (job.op)
			OP_PUSH: begin
				if (fill_q < cap_eff)
					nf = fill_q + 1'b1;
				else
					no = wrap_add(oldest_q, CNT_W'(1));
			end
			OP_POP: begin
				n_cnt = (int'(job.req) < int'(fill_q)) ? CNT_W'(job.req) : fill_q;
				no    = wrap_add(oldest_q, n_cnt);
				nf    = fill_q - n_cnt;
			end
			OP_PEEK: begin
				n_cnt = (int'(job.req) < int'(fill_q)) ? CNT_W'(job.req) : fill_q;
			end
			default: ;
		endcase
		blen_ok = int'(blen_eff) <= int'(nf);
		elen_ok = int'(elen_eff) <= int'(nf);
	end

	assign rd_addr_a = (state_q == ST_EMIT) ? ea_q : pa_q;

	// ring store: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[wr_addr] <= job.ch;
		rd_a_q <= mem[rd_addr_a];
		rd_b_q <= mem[sa_q];
	end

	// payload-only registers
	always_ff @(posedge clk) begin
		e_cv_s1   <= !zero_q;
		e_last_s1 <= zero_q || (left_q == CNT_W'(1));
		e_bm_s1   <= bm_q;
		e_em_s1   <= em_q;
		e_fill_s1 <= fill_q;
		ri_s1     <= wc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			capacity_q <= CAPACITY_RST;
			bpat_q     <= PAT_W'(BEGIN_PAT_RST);
			blen_q     <= BEGIN_LEN_RST;
			epat_q     <= PAT_W'(END_PAT_RST);
			elen_q     <= END_LEN_RST;
			oldest_q   <= '0;
			fill_q     <= '0;
			pa_q       <= '0;
			sa_q       <= '0;
			ea_q       <= '0;
			wc_q       <= '0;
			bm_q       <= 1'b0;
			em_q       <= 1'b0;
			left_q     <= '0;
			zero_q     <= 1'b0;
			rv_s1      <= 1'b0;
			e_vld_s1   <= 1'b0;
		end else begin
			e_vld_s1 <= 1'b0;
			rv_s1    <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_CAPACITY: begin
						capacity_q <= cfg_data[CAP_W-1:0];
						if (fill_q > trim_cap) begin
							oldest_q <= wrap_add(oldest_q, fill_q - trim_cap);
							fill_q   <= trim_cap;
						end
					end
					CFG_BEGIN_PAT: bpat_q <= cfg_data[PAT_W-1:0];
					CFG_BEGIN_LEN: blen_q <= cfg_data[LEN_W-1:0];
					CFG_END_PAT:   epat_q <= cfg_data[PAT_W-1:0];
					CFG_END_LEN:   elen_q <= cfg_data[LEN_W-1:0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						oldest_q <= no;
						fill_q   <= nf;
						pa_q     <= no;
						sa_q     <= elen_ok ? wrap_add(no, nf - CNT_W'(elen_eff)) : no;
						bm_q     <= blen_ok;
						em_q     <= elen_ok;
						wc_q     <= '0;
						ea_q     <= oldest_q;
						left_q   <= n_cnt;
						zero_q   <= (n_cnt == '0);
						state_q  <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (wc_q < PLEN_W'(PATTERN_CHARS)) begin
						rv_s1 <= 1'b1;
						pa_q  <= wrap_add(pa_q, CNT_W'(1));
						sa_q  <= wrap_add(sa_q, CNT_W'(1));
						wc_q  <= wc_q + 1'b1;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					e_vld_s1 <= 1'b1;
					ea_q     <= wrap_add(ea_q, CNT_W'(1));
					if (zero_q || left_q == CNT_W'(1))
						state_q <= ST_IDLE;
					else
						left_q <= left_q - 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
			// compare the byte read on the previous walk step
			if (rv_s1) begin
				if (ri_s1 < blen_eff && rd_a_q != bpat_q[8*ri_s1 +: 8])
					bm_q <= 1'b0;
				if (ri_s1 < elen_eff && rd_b_q != epat_q[8*ri_s1 +: 8])
					em_q <= 1'b0;
			end
		end
	end

	always_comb begin
		result_valid        = e_vld_s1;
		result.char_out     = e_cv_s1 ? rd_a_q : 8'd0;
		result.char_valid   = e_cv_s1;
		result.last         = e_last_s1;
		result.fill_count   = FILL_W'(e_fill_s1);
		result.begins_match = e_bm_s1;
		result.ends_match   = e_em_s1;
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(DEPTH))
		else $error("fill above ring depth");

	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		e_vld_s1 |-> $past(state_q == ST_EMIT))
		else $error("result issued outside emission");

	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && left_q <= CNT_W'(1)) |=> (e_vld_s1 && e_last_s1))
		else $error("final result not marked last");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wc_q <= PLEN_W'(PATTERN_CHARS))
		else $error("walk counter past pattern length");

endmodule

// File: hw/rtl/char_ring_fifo_prefix_suffix_match.sv
// Top level of the character ring FIFO with prefix/suffix match flags.
// Depends on crf_pkg, crf_front and crf_back.
//
//  channel   signals                             transfer when
//  --------  ----------------------------------  ---------------------------
//  command   start, busy, item                   start && !busy
//  config    cfg_valid, cfg_ready, cfg_index,    cfg_valid && cfg_ready
//            cfg_data                            (cfg_ready is always high)
//  result    result_valid, result                result_valid (one cycle)
//
// A command is dispatched, then the match walk steps over the eight pattern
// positions (two registered read ports on the ring store, each compare in the
// cycle after its read), then max(n,1) results go out, n = characters emitted.
// The back end takes the next command only after the last result is issued.
// The front queue holds two commands, so busy rises only when both slots wait.
// Reset clears pointers, fill and sequencer and sets config registers to reset
// values; the character store is not cleared. The receiver cannot stall results.
module char_ring_fifo_prefix_suffix_match (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  crf_pkg::crf_item_t          item,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [crf_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [crf_pkg::CDATA_W-1:0] cfg_data,
	output logic                        result_valid,
	output crf_pkg::crf_result_t        result
);
	import crf_pkg::*;

	crf_job_t job;
	logic     job_valid;
	logic     job_take;

	// registers take every write, so config never waits
	assign cfg_ready = 1'b1;

	crf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.job_valid (job_valid),
		.job       (job),
		.job_take  (job_take)
	);

	// back end owns the ring and the config registers
	crf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (job_valid),
		.job          (job),
		.job_take     (job_take),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

// File: tb/tb_char_ring_fifo_prefix_suffix_match.sv
`timescale 1ns / 100ps
// Self-checking bench for the character ring FIFO with prefix/suffix match flags.
// Depends on crf_pkg and char_ring_fifo_prefix_suffix_match (plus its submodules).

module tb_char_ring_fifo_prefix_suffix_match;
	import crf_pkg::*;

	localparam int CLK_HALF        = 10;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int RANDOM_PHASES   = 6;
	localparam int ITEMS_PER_PHASE = 70;
	localparam int SETTLE_CYCLES   = 20;      // back end is idle once the last result is out

	// Tracks the FIFO contents, the registers and the results still owed by the block.
	class fifo_match_tracker;
		logic [7:0]         ring [DEPTH];
		logic [IDX_W-1:0]   head;
		logic [FILL_W-1:0]  fill;
		logic [CAP_W-1:0]   capacity;
		logic [CDATA_W-1:0] begin_pat;
		logic [CDATA_W-1:0] end_pat;
		logic [LEN_W-1:0]   begin_len;
		logic [LEN_W-1:0]   end_len;
		crf_result_t        expected_results [$];
		int                 errors;
		int                 checked;
		int                 prefix_hits;
		int                 suffix_hits;

		function new();
			head        = '0;
			fill        = '0;
			capacity    = CAPACITY_RST;
			begin_pat   = BEGIN_PAT_RST;
			begin_len   = BEGIN_LEN_RST;
			end_pat     = END_PAT_RST;
			end_len     = END_LEN_RST;
			errors      = 0;
			checked     = 0;
			prefix_hits = 0;
			suffix_hits = 0;
		endfunction

		task report_mismatch(string what);
			$display("[%0t] mismatch: %s", $time, what);
			errors++;
		endtask

		function int capacity_limit();
			if (capacity == '0)
				return 1;
			if (int'(capacity) > DEPTH)
				return DEPTH;
			return int'(capacity);
		endfunction

		function int pattern_len(logic [LEN_W-1:0] len);
			return (int'(len) > PATTERN_CHARS) ? PATTERN_CHARS : int'(len);
		endfunction

		function bit run_matches(logic [CDATA_W-1:0] pat, int len, int off);
			for (int i = 0; i < len; i++)
				if (ring[IDX_W'(int'(head) + off + i)] !== pat[8*i +: 8])
					return 1'b0;
			return 1'b1;
		endfunction

		function bit prefix_hit();
			int len;
			len = pattern_len(begin_len);
			if (len > int'(fill))
				return 1'b0;
			return run_matches(begin_pat, len, 0);
		endfunction

		function bit suffix_hit();
			int len;
			len = pattern_len(end_len);
			if (len > int'(fill))
				return 1'b0;
			return run_matches(end_pat, len, int'(fill) - len);
		endfunction

		function void apply_register(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] data);
			case (idx)
				CFG_CAPACITY: begin
					capacity = data[CAP_W-1:0];
					// lowering capacity drops the oldest excess characters
					if (int'(fill) > capacity_limit()) begin
						head = IDX_W'(int'(head) + int'(fill) - capacity_limit());
						fill = FILL_W'(capacity_limit());
					end
				end
				CFG_BEGIN_PAT: begin_pat = data;
				CFG_BEGIN_LEN: begin_len = data[LEN_W-1:0];
				CFG_END_PAT:   end_pat = data;
				CFG_END_LEN:   end_len = data[LEN_W-1:0];
				default: ;
			endcase
		endfunction

		function void accept_command(crf_item_t it);
			logic [7:0]  got [DEPTH];
			int          n;
			crf_result_t r;
			n = 0;
			case (crf_op_t'(it.command))
				OP_PUSH: begin
					ring[IDX_W'(int'(head) + int'(fill))] = it.char_in;
					if (int'(fill) < capacity_limit())
						fill = fill + 1'b1;
					else
						head = head + 1'b1;
				end
				OP_POP, OP_PEEK: begin
					n = (it.request_count < fill) ? int'(it.request_count) : int'(fill);
					for (int k = 0; k < n; k++)
						got[k] = ring[IDX_W'(int'(head) + k)];
					if (it.command == OP_POP) begin
						head = IDX_W'(int'(head) + n);
						fill = fill - FILL_W'(n);
					end
				end
				default: ;
			endcase
			r.char_out     = '0;
			r.char_valid   = 1'b0;
			r.last         = 1'b1;
			r.fill_count   = fill;
			r.begins_match = prefix_hit();
			r.ends_match   = suffix_hit();
			if (n == 0)
				expected_results.push_back(r);
			for (int k = 0; k < n; k++) begin
				r.char_out   = got[k];
				r.char_valid = 1'b1;
				r.last       = (k == n - 1);
				expected_results.push_back(r);
			end
		endfunction

		task check_result(crf_result_t got);
			crf_result_t want;
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result %h with none expected", got));
				return;
			end
			want = expected_results.pop_front();
			checked++;
			if (want.begins_match)
				prefix_hits++;
			if (want.ends_match)
				suffix_hits++;
			if (got.char_out !== want.char_out)
				report_mismatch($sformatf("char_out %h, expected %h",
					got.char_out, want.char_out));
			if (got.char_valid !== want.char_valid)
				report_mismatch($sformatf("char_valid %b, expected %b",
					got.char_valid, want.char_valid));
			if (got.last !== want.last)
				report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
			if (got.fill_count !== want.fill_count)
				report_mismatch($sformatf("fill_count %0d, expected %0d",
					got.fill_count, want.fill_count));
			if (got.begins_match !== want.begins_match)
				report_mismatch($sformatf("begins_match %b, expected %b",
					got.begins_match, want.begins_match));
			if (got.ends_match !== want.ends_match)
				report_mismatch($sformatf("ends_match %b, expected %b",
					got.ends_match, want.ends_match));
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	crf_item_t          item;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CIDX_W-1:0]  cfg_index;
	logic [CDATA_W-1:0] cfg_data;
	logic               result_valid;
	crf_result_t        result;

	fifo_match_tracker tracker;
	int cycles       = 0;
	int items_sent   = 0;
	int settings_run = 0;
	int burst_left   = 0;
	bit idle_enabled = 1'b1;

	char_ring_fifo_prefix_suffix_match dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// watchdog: a hung handshake or a lost result ends the run here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("watchdog expired after %0d cycles, %0d results outstanding",
				cycles, tracker.expected_results.size());
			$display("FAILURE");
			$finish;
		end
	end

	// results are one-cycle strobes; sample them on the edge that ends the cycle
	always @(posedge clk) begin
		if (arst_n && result_valid)
			tracker.check_result(result);
	end

	function automatic crf_item_t make_item(crf_op_t op, logic [7:0] ch,
			logic [REQ_W-1:0] req);
		crf_item_t it;
		it.command       = op;
		it.char_in       = ch;
		it.request_count = req;
		return it;
	endfunction

	// a quarter short asks (0..3), a quarter "everything", half anywhere in 0..DEPTH
	function automatic logic [REQ_W-1:0] pick_request();
		case ($urandom_range(0, 3))
			0:       return REQ_W'(DEPTH);
			1:       return REQ_W'($urandom_range(0, 3));
			default: return REQ_W'($urandom_range(0, DEPTH));
		endcase
	endfunction

	// One command transfer. Bursts of random length, then a random gap with start low;
	// start stays high across back-to-back commands so it is never dropped and raised
	// in the same step.
	task automatic send_command(crf_item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = 0;
			if (idle_enabled)
				gap = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
					: $urandom_range(0, 12);
			if (gap > 0) begin
				start <= 1'b0;
				item  <= make_item(crf_op_t'($urandom_range(0, 3)), 8'($urandom),
					REQ_W'($urandom));
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		if (!start)
			start <= 1'b1;
		item <= it;
		do
			@(posedge clk);
		while (busy);
		tracker.accept_command(it);
		items_sent++;
	endtask

	// wait until every owed result is back, then let the back end go quiet
	task automatic drain();
		if (start)
			start <= 1'b0;
		burst_left = 0;
		while (tracker.expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_config(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] data);
		if (!cfg_valid)
			cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		tracker.apply_register(idx, data);
	endtask

	// Full register set, back to back. Junk above each field's width must be ignored,
	// and so must an index past the end of the map.
	task automatic configure(logic [CAP_W-1:0] cap, logic [CDATA_W-1:0] bpat,
			logic [LEN_W-1:0] blen, logic [CDATA_W-1:0] epat, logic [LEN_W-1:0] elen);
		logic [CDATA_W-1:0] junk;
		junk = {$urandom, $urandom};
		send_config(CFG_CAPACITY, {junk[CDATA_W-1:CAP_W], cap});
		send_config(CFG_BEGIN_PAT, bpat);
		junk = {$urandom, $urandom};
		send_config(CFG_BEGIN_LEN, {junk[CDATA_W-1:LEN_W], blen});
		send_config(CFG_END_PAT, epat);
		junk = {$urandom, $urandom};
		send_config(CFG_END_LEN, {junk[CDATA_W-1:LEN_W], elen});
		send_config(CFG_END_LEN + CIDX_W'($urandom_range(1, 3)), {$urandom, $urandom});
		cfg_valid <= 1'b0;
		settings_run++;
	endtask

	// One register setting followed by a mix of pattern-building runs and loose traffic.
	// Random characters almost never match, so a good part of the pushes replay the
	// configured prefix/suffix bytes to drive both flags high.
	task automatic random_phase(int phase, int count);
		logic [CAP_W-1:0]   cap;
		logic [LEN_W-1:0]   blen;
		logic [LEN_W-1:0]   elen;
		logic [CDATA_W-1:0] bpat;
		logic [CDATA_W-1:0] epat;
		logic [CDATA_W-1:0] src;
		int                 sent_here;
		int                 roll;
		int                 len;
		bpat = {$urandom, $urandom};
		epat = {$urandom, $urandom};
		blen = LEN_W'($urandom_range(0, 9));
		elen = LEN_W'($urandom_range(0, 9));
		cap  = CAP_W'($urandom_range(2, 15));
		case (phase)
			0: begin  // single-entry FIFO, longest prefix, oversized suffix length
				cap  = CAP_W'(1);
				blen = LEN_W'(PATTERN_CHARS);
				elen = '1;
			end
			1: begin  // full depth, all-ones patterns, empty prefix
				cap  = CAP_W'(DEPTH);
				bpat = '1;
				epat = '1;
				blen = '0;
				elen = LEN_W'(PATTERN_CHARS);
			end
			2: begin  // capacity field at its top, all-zero patterns
				cap  = '1;
				bpat = '0;
				epat = '0;
				blen = '1;
				elen = '0;
			end
			3: cap = '0;  // behaves as capacity 1
			default: ;
		endcase
		configure(cap, bpat, blen, epat, elen);

		sent_here = 0;
		while (sent_here < count) begin
			roll = $urandom_range(0, 99);
			if (roll < 15) begin
				// suffix run
				len = tracker.pattern_len(tracker.end_len);
				for (int i = 0; i < len; i++)
					send_command(make_item(OP_PUSH, tracker.end_pat[8*i +: 8],
						REQ_W'($urandom)));
				sent_here += len + 1;
			end else if (roll < 25) begin
				// empty the FIFO, then lay down the prefix from the oldest slot
				send_command(make_item(OP_POP, 8'($urandom), REQ_W'(DEPTH)));
				len = tracker.pattern_len(tracker.begin_len);
				for (int i = 0; i < len; i++)
					send_command(make_item(OP_PUSH, tracker.begin_pat[8*i +: 8],
						REQ_W'($urandom)));
				sent_here += len + 1;
			end else if (roll < 60) begin
				src = $urandom_range(0, 1) ? tracker.begin_pat : tracker.end_pat;
				send_command(make_item(OP_PUSH,
					$urandom_range(0, 1) ? 8'($urandom)
						: src[8*$urandom_range(0, PATTERN_CHARS - 1) +: 8],
					REQ_W'($urandom)));
				sent_here++;
			end else if (roll < 75) begin
				send_command(make_item(OP_POP, 8'($urandom), pick_request()));
				sent_here++;
			end else if (roll < 94) begin
				send_command(make_item(OP_PEEK, 8'($urandom), pick_request()));
				sent_here++;
			end else begin
				send_command(make_item(OP_NOP, 8'($urandom), REQ_W'($urandom)));
				sent_here++;
			end
		end
	endtask

	initial begin
		tracker = new();
		arst_n    <= 1'b0;
		start     <= 1'b0;
		item      <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed, reset registers: prefix "123", suffix "abcd" ---
		send_command(make_item(OP_POP, 8'hA5, REQ_W'(4)));         // read on empty
		send_command(make_item(OP_PEEK, 8'h00, '0));               // zero request, empty
		for (int i = 0; i < 3; i++)
			send_command(make_item(OP_PUSH, BEGIN_PAT_RST[8*i +: 8], '0));
		for (int i = 0; i < 4; i++)
			send_command(make_item(OP_PUSH, END_PAT_RST[8*i +: 8], '1));
		send_command(make_item(OP_PEEK, 8'hFF, '0));               // zero request, data held
		send_command(make_item(OP_PEEK, 8'h00, REQ_W'(DEPTH)));    // clamped to fill
		send_command(make_item(OP_POP, 8'h5A, REQ_W'(2)));         // breaks the prefix
		send_command(make_item(OP_NOP, 8'hFF, REQ_W'(DEPTH)));     // unknown command
		send_command(make_item(OP_PUSH, 8'h00, '1));
		send_command(make_item(OP_PUSH, 8'hFF, '0));
		drain();

		// capacity 0 trims seven held characters down to one; empty prefix always
		// matches, oversized suffix length acts as eight and cannot match one char
		configure('0, BEGIN_PAT_RST, '0, END_PAT_RST, '1);
		for (int i = 0; i < 3; i++)
			send_command(make_item(OP_PUSH, 8'($urandom), REQ_W'($urandom)));
		send_command(make_item(OP_PEEK, 8'($urandom), REQ_W'(DEPTH)));
		send_command(make_item(OP_POP, 8'($urandom), REQ_W'(DEPTH)));
		drain();

		// --- random phases, one register setting each; phase 2 runs without gaps ---
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			idle_enabled = (p != 2);
			random_phase(p, ITEMS_PER_PHASE);
			drain();
		end

		if (tracker.expected_results.size() != 0)
			tracker.report_mismatch($sformatf("%0d results never arrived",
				tracker.expected_results.size()));
		$display("%0d commands over %0d register settings, %0d results checked",
			items_sent, settings_run + 1, tracker.checked);
		$display("prefix flag set on %0d results, suffix flag on %0d, %0d mismatches",
			tracker.prefix_hits, tracker.suffix_hits, tracker.errors);
		if (tracker.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: char_ring_fifo_prefix_suffix_match.f
hw/rtl/crf_pkg.sv
hw/rtl/crf_front.sv
hw/rtl/crf_back.sv
hw/rtl/char_ring_fifo_prefix_suffix_match.sv
tb/tb_char_ring_fifo_prefix_suffix_match.sv
